/* design/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

/* design/tbrp_pkg.sv */
package tbrp_pkg;

   localparam int REC_LEN      = 20;
   localparam int GROUP_LEN    = 8;
   localparam int TAIL_LEN     = 4;
   localparam int DATA_LEN     = 17;
   localparam int MAX_STATIONS = 2;

   localparam logic [7:0] STATION_BASE = 8'd49;
   localparam logic [7:0] CHAR_AT      = 8'h40;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;

   localparam logic [1:0] STATION_COUNT_RESET = 2'd2;
   localparam logic [1:0] BUTTON_MASK_RESET   = 2'd0;

   typedef enum logic [0:0] {
      CSR_STATION_COUNT = 1'b0,
      CSR_BUTTON_MASK   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_GOOD        = 2'd0,
      STATUS_STRAY       = 2'd1,
      STATUS_BAD_STATION = 2'd2
   } status_type;

   typedef struct packed {
      status_type         status;
      logic               station;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic               button_valid;
      logic               button_pressed;
   } result_type;

endpackage

/* design/tracker_binary_record_parser.sv */
// Binary record parser for a motion tracker serial link. Feed one received byte per
// req_ transfer; bytes are dropped until one arrives with its top bit set, which opens a
// 20-byte record. The transfer that carries the 20th byte produces exactly one rsp_
// transfer: record_status 0 with station, three raw position counts, four raw
// quaternion counts and stylus button state, or status 1 (a later byte had its top bit
// set) or 2 (station digit out of range), with every other field zero. A byte is taken
// in every cycle while req_stall is low. The record decode is pure wiring plus compares
// between the stored bytes and a single result register, so the result appears in the
// cycle after its last byte. The only back pressure is that result register: req_stall
// is high while a result waits and rsp_stall holds it. station_count and button_mask
// reset to 2 and 0. Write them only while the link is idle; the block does not enforce it.
`include "assert_macros.svh"

module tracker_binary_record_parser
   import tbrp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_record_status,
   output logic               rsp_station,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic signed [15:0] rsp_pos_z,
   output logic signed [15:0] rsp_quat_w,
   output logic signed [15:0] rsp_quat_x,
   output logic signed [15:0] rsp_quat_y,
   output logic signed [15:0] rsp_quat_z,
   output logic               rsp_button_valid,
   output logic               rsp_button_pressed,
   input  logic               csr_write,
   input  logic [0:0]         csr_index,
   input  logic [1:0]         csr_data
);

   localparam int          CNT_W         = $clog2(REC_LEN);
   localparam logic [CNT_W-1:0] LAST_INDEX = CNT_W'(REC_LEN - 1);
   localparam logic [3:0]  MAX_STATIONS_W = 4'(MAX_STATIONS);

   // configuration
   logic [1:0]       station_count_ff;
   logic [1:0]       button_mask_ff;

   // record capture
   logic             in_record_ff;
   logic             in_record_in;
   logic [CNT_W-1:0] byte_count_ff;
   logic [CNT_W-1:0] byte_count_in;
   logic             stray_ff;
   logic             stray_in;
   logic [7:0]       rec_ff [REC_LEN-1];

   // result register
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   result_type       result_ff;
   result_type       result_in;

   logic             req_accept;
   logic             last_byte;
   logic             stray_any;
   logic [7:0]       rec_all [REC_LEN];
   logic [7:0]       dec [DATA_LEN];
   logic [7:0]       station_diff;
   logic [3:0]       station_limit;
   logic             station_ok;
   logic             has_button;

   // Hold new bytes only while a finished result is stalled at the output.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign last_byte  = in_record_ff && (byte_count_ff == LAST_INDEX);
   assign stray_any  = stray_ff || req_rx_byte[7];

   always_ff @(posedge clock) begin
      if (reset) begin
         station_count_ff <= STATION_COUNT_RESET;
         button_mask_ff   <= BUTTON_MASK_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_STATION_COUNT: station_count_ff <= csr_data;
            CSR_BUTTON_MASK:   button_mask_ff   <= csr_data;
            default:           ;
         endcase
      end
   end

   // Capture sequencing: hunt for a sync byte, then count 19 more bytes.
   always_comb begin
      in_record_in  = in_record_ff;
      byte_count_in = byte_count_ff;
      stray_in      = stray_ff;
      if (req_accept) begin
         if (!in_record_ff) begin
            if (req_rx_byte[7]) begin
               in_record_in  = 1'b1;
               byte_count_in = CNT_W'(1);
               stray_in      = 1'b0;
            end
         end else if (last_byte) begin
            in_record_in  = 1'b0;
            byte_count_in = '0;
            stray_in      = 1'b0;
         end else begin
            byte_count_in = byte_count_ff + CNT_W'(1);
            stray_in      = stray_any;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_record_ff  <= 1'b0;
         byte_count_ff <= '0;
         stray_ff      <= 1'b0;
      end else begin
         in_record_ff  <= in_record_in;
         byte_count_ff <= byte_count_in;
         stray_ff      <= stray_in;
      end
   end

   // Store bytes 0..18; the 20th byte is decoded straight from the input.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (!in_record_ff && req_rx_byte[7]) begin
            rec_ff[0] <= req_rx_byte;
         end else if (in_record_ff && !last_byte) begin
            rec_ff[byte_count_ff] <= req_rx_byte;
         end
      end
   end

   // Restore the eighth bits: each group's closing byte carries them from bit 0 up.
   always_comb begin
      for (int i = 0; i < REC_LEN - 1; i++) begin
         rec_all[i] = rec_ff[i];
      end
      rec_all[REC_LEN-1] = req_rx_byte;
      for (int k = 0; k < GROUP_LEN - 1; k++) begin
         dec[k] = rec_all[k] | {rec_all[GROUP_LEN-1][k], 7'b0};
         dec[GROUP_LEN-1+k] = rec_all[GROUP_LEN+k] | {rec_all[2*GROUP_LEN-1][k], 7'b0};
      end
      for (int k = 0; k < TAIL_LEN - 1; k++) begin
         dec[2*(GROUP_LEN-1)+k] = rec_all[2*GROUP_LEN+k] | {rec_all[REC_LEN-1][k], 7'b0};
      end
   end

   // Station digit is ASCII based at '1'; clamp the active count to the build limit.
   assign station_diff  = dec[1] - STATION_BASE;
   assign station_limit = ({2'b0, station_count_ff} > MAX_STATIONS_W) ?
                          MAX_STATIONS_W : {2'b0, station_count_ff};
   assign station_ok    = (dec[1] >= STATION_BASE) &&
                          (station_diff < {4'b0, station_limit});
   assign has_button    = (station_diff < 8'd2) && button_mask_ff[station_diff[0]];

   always_comb begin
      result_in = '0;
      if (stray_any) begin
         result_in.status = STATUS_STRAY;
      end else if (!station_ok) begin
         result_in.status = STATUS_BAD_STATION;
      end else begin
         result_in.status  = STATUS_GOOD;
         result_in.station = station_diff[0];
         result_in.pos_x   = $signed({dec[4],  dec[3]});
         result_in.pos_y   = $signed({dec[6],  dec[5]});
         result_in.pos_z   = $signed({dec[8],  dec[7]});
         result_in.quat_w  = $signed({dec[10], dec[9]});
         result_in.quat_x  = $signed({dec[12], dec[11]});
         result_in.quat_y  = $signed({dec[14], dec[13]});
         result_in.quat_z  = $signed({dec[16], dec[15]});
         if (has_button && (dec[2] == CHAR_AT || dec[2] == CHAR_STAR)) begin
            result_in.button_valid   = 1'b1;
            result_in.button_pressed = (dec[2] == CHAR_AT);
         end
      end
   end

   // Load a result on the closing byte; drop it once the downstream side takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (req_accept && last_byte) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && last_byte) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_record_status  = result_ff.status;
   assign rsp_station        = result_ff.station;
   assign rsp_pos_x          = result_ff.pos_x;
   assign rsp_pos_y          = result_ff.pos_y;
   assign rsp_pos_z          = result_ff.pos_z;
   assign rsp_quat_w         = result_ff.quat_w;
   assign rsp_quat_x         = result_ff.quat_x;
   assign rsp_quat_y         = result_ff.quat_y;
   assign rsp_quat_z         = result_ff.quat_z;
   assign rsp_button_valid   = result_ff.button_valid;
   assign rsp_button_pressed = result_ff.button_pressed;

   `ASSERT_NEXT(a_result_after_last, clock, reset, req_accept && last_byte, rsp_valid_ff, "closing byte gave no result")
   `ASSERT_NOW(a_count_in_record, clock, reset, in_record_ff, (byte_count_ff != '0) && (byte_count_ff <= LAST_INDEX), "byte count out of range in record")
   `ASSERT_NOW(a_count_hunting, clock, reset, !in_record_ff, byte_count_ff == '0, "byte count nonzero while hunting")
   `ASSERT_NOW(a_error_zero_fields, clock, reset, rsp_valid_ff && (result_ff.status != STATUS_GOOD), (result_ff.pos_x == 16'sd0) && !result_ff.button_valid && !result_ff.station, "rejected record carries data")

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import tbrp_pkg::*;

   // Far above the slowest correct run: about 1000 bytes under the heaviest idling and stalling.
   localparam int CYCLE_LIMIT = 200000;
   // The result appears in the cycle after the last byte; settle before a CSR write.
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_BYTES = 220;

   typedef logic [15:0] word_set_type [7];

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_record_status;
   logic               rsp_station;
   logic signed [15:0] rsp_pos_x;
   logic signed [15:0] rsp_pos_y;
   logic signed [15:0] rsp_pos_z;
   logic signed [15:0] rsp_quat_w;
   logic signed [15:0] rsp_quat_x;
   logic signed [15:0] rsp_quat_y;
   logic signed [15:0] rsp_quat_z;
   logic               rsp_button_valid;
   logic               rsp_button_pressed;
   logic               csr_write = 1'b0;
   logic [0:0]         csr_index = CSR_STATION_COUNT;
   logic [1:0]         csr_data = 2'd0;

   // Bytes waiting to go out and decoded records waiting to come back.
   logic [7:0]  pending_bytes [$];
   result_type  expected_records [$];

   // Our own copy of the parser state and its two registers.
   logic        parse_in_record = 1'b0;
   int          parse_count = 0;
   logic [7:0]  parse_bytes [REC_LEN];
   logic        parse_stray = 1'b0;
   logic [1:0]  cfg_station_count = STATION_COUNT_RESET;
   logic [1:0]  cfg_button_mask = BUTTON_MASK_RESET;

   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;

   result_type  got_record;
   result_type  want_record;

   always #6 clock = ~clock;

   tracker_binary_record_parser dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_record_status  (rsp_record_status),
      .rsp_station        (rsp_station),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_pos_z          (rsp_pos_z),
      .rsp_quat_w         (rsp_quat_w),
      .rsp_quat_x         (rsp_quat_x),
      .rsp_quat_y         (rsp_quat_y),
      .rsp_quat_z         (rsp_quat_z),
      .rsp_button_valid   (rsp_button_valid),
      .rsp_button_pressed (rsp_button_pressed),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // Advance the parser copy by one accepted byte; push a decoded record when the
   // twentieth byte of a record lands.
   function automatic void absorb_rx_byte(logic [7:0] rx);
      logic [7:0] data [DATA_LEN];
      logic [7:0] idx;
      int         active;
      result_type rec;
      rec = '0;
      // Hunting: drop bytes until the top bit shows up.
      if (!parse_in_record) begin
         if (rx[7]) begin
            parse_bytes[0] = rx;
            parse_count = 1;
            parse_stray = 1'b0;
            parse_in_record = 1'b1;
         end
         return;
      end
      parse_bytes[parse_count] = rx;
      // A later sync bit does not restart the record; it only taints it.
      if (rx[7]) parse_stray = 1'b1;
      parse_count++;
      if (parse_count < REC_LEN) return;
      parse_in_record = 1'b0;
      parse_count = 0;
      if (parse_stray) begin
         // Stray sync wins over a bad station; every other field stays zero.
         parse_stray = 1'b0;
         rec.status = STATUS_STRAY;
         expected_records.push_back(rec);
         return;
      end
      // Restore the eighth bits from the closing byte of each group and of the tail.
      for (int k = 0; k < GROUP_LEN - 1; k++) begin
         data[k]     = parse_bytes[k]     | {parse_bytes[GROUP_LEN - 1][k], 7'd0};
         data[7 + k] = parse_bytes[8 + k] | {parse_bytes[2 * GROUP_LEN - 1][k], 7'd0};
      end
      for (int k = 0; k < TAIL_LEN - 1; k++)
         data[14 + k] = parse_bytes[16 + k] | {parse_bytes[REC_LEN - 1][k], 7'd0};
      active = (int'(cfg_station_count) > MAX_STATIONS) ? MAX_STATIONS
                                                         : int'(cfg_station_count);
      idx = data[1] - STATION_BASE;
      if (data[1] < STATION_BASE || int'(idx) >= active) begin
         rec.status = STATUS_BAD_STATION;
         expected_records.push_back(rec);
         return;
      end
      rec.status  = STATUS_GOOD;
      rec.station = idx[0];
      rec.pos_x   = {data[4], data[3]};
      rec.pos_y   = {data[6], data[5]};
      rec.pos_z   = {data[8], data[7]};
      rec.quat_w  = {data[10], data[9]};
      rec.quat_x  = {data[12], data[11]};
      rec.quat_y  = {data[14], data[13]};
      rec.quat_z  = {data[16], data[15]};
      // Only stations with a mask bit have a button; any other status byte means none.
      if (idx < 2 && cfg_button_mask[idx[0]] && (data[2] == CHAR_AT || data[2] == CHAR_STAR))
      begin
         rec.button_valid   = 1'b1;
         rec.button_pressed = (data[2] == CHAR_AT);
      end
      expected_records.push_back(rec);
   endfunction

   function automatic string format_record(result_type r);
      return $sformatf("status %0d station %0d pos %0d %0d %0d quat %0d %0d %0d %0d btn %0b/%0b",
                       r.status, r.station, r.pos_x, r.pos_y, r.pos_z,
                       r.quat_w, r.quat_x, r.quat_y, r.quat_z,
                       r.button_valid, r.button_pressed);
   endfunction

   // Pack 17 data bytes into the 20-byte wire format and queue them. A nonzero
   // stray_at forces the top bit of that byte.
   task automatic queue_record(logic [7:0] station_char, logic [7:0] button_char,
                               word_set_type words, int stray_at);
      logic [7:0] data [DATA_LEN];
      logic [7:0] raw [REC_LEN];
      data[0] = 8'($urandom);
      data[1] = station_char;
      data[2] = button_char;
      for (int i = 0; i < 7; i++) begin
         data[3 + 2 * i] = words[i][7:0];
         data[4 + 2 * i] = words[i][15:8];
      end
      raw[7]  = 8'h00;
      raw[15] = 8'h00;
      for (int k = 0; k < GROUP_LEN - 1; k++) begin
         raw[k]      = {1'b0, data[k][6:0]};
         raw[7][k]   = data[k][7];
         raw[8 + k]  = {1'b0, data[7 + k][6:0]};
         raw[15][k]  = data[7 + k][7];
      end
      // Unused bits of the tail's high-bit byte carry noise.
      raw[19] = {1'b0, 4'($urandom), 3'b000};
      for (int k = 0; k < TAIL_LEN - 1; k++) begin
         raw[16 + k] = {1'b0, data[14 + k][6:0]};
         raw[19][k]  = data[14 + k][7];
      end
      raw[0][7] = 1'b1;
      if (stray_at > 0) raw[stray_at][7] = 1'b1;
      for (int k = 0; k < REC_LEN; k++) pending_bytes.push_back(raw[k]);
   endtask

   // Mostly well-formed records with random content, plus hunting noise and raw junk.
   task automatic queue_random(int target);
      int           queued;
      int           pick;
      int           stray_at;
      logic [7:0]   station_char;
      logic [7:0]   button_char;
      word_set_type words;
      queued = 0;
      while (queued < target) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            // Noise while hunting: top bit clear, dropped by the parser.
            repeat ($urandom_range(3, 1)) pending_bytes.push_back(8'($urandom) & 8'h7F);
         end else if (pick < 14) begin
            // Sync followed by junk: almost always a stray-sync record.
            pending_bytes.push_back(8'($urandom) | 8'h80);
            repeat (REC_LEN - 1) pending_bytes.push_back(8'($urandom));
            queued += REC_LEN;
         end else begin
            pick = $urandom_range(99);
            if (pick < 40)      station_char = STATION_BASE;
            else if (pick < 75) station_char = STATION_BASE + 8'd1;
            else if (pick < 85) station_char = STATION_BASE + 8'd2;
            else if (pick < 90) station_char = STATION_BASE - 8'd1;
            else                station_char = 8'($urandom);
            pick = $urandom_range(99);
            if (pick < 35)      button_char = CHAR_AT;
            else if (pick < 70) button_char = CHAR_STAR;
            else                button_char = 8'($urandom);
            for (int i = 0; i < 7; i++) begin
               case ($urandom_range(9))
                  0:       words[i] = 16'h8000;
                  1:       words[i] = 16'h7FFF;
                  2:       words[i] = 16'hFFFF;
                  3:       words[i] = 16'h0000;
                  default: words[i] = 16'($urandom);
               endcase
            end
            stray_at = ($urandom_range(9) == 0) ? $urandom_range(REC_LEN - 1, 1) : 0;
            queue_record(station_char, button_char, words, stray_at);
            queued += REC_LEN;
         end
      end
   endtask

   // Hold the sender until every byte is out, close any open record with zero bytes,
   // then wait for every expected record and let the block settle.
   task automatic drain_link();
      forever begin
         do @(negedge clock); while (pending_bytes.size() != 0 || req_valid);
         if (!parse_in_record) break;
         repeat (REC_LEN - parse_count) pending_bytes.push_back(8'h00);
      end
      while (expected_records.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      if (idx == CSR_STATION_COUNT) cfg_station_count = value;
      else                          cfg_button_mask = value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_pace(int idle_pct, int stall_pct);
      @(negedge clock);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
   endtask

   // Driver: account for the transfer that just happened, then present the next byte
   // or go idle. A stalled byte is held unchanged.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) absorb_rx_byte(req_rx_byte);
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid   <= 1'b1;
               req_rx_byte <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result transfer against the oldest expected record.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_record.status         = status_type'(rsp_record_status);
            got_record.station        = rsp_station;
            got_record.pos_x          = rsp_pos_x;
            got_record.pos_y          = rsp_pos_y;
            got_record.pos_z          = rsp_pos_z;
            got_record.quat_w         = rsp_quat_w;
            got_record.quat_x         = rsp_quat_x;
            got_record.quat_y         = rsp_quat_y;
            got_record.quat_z         = rsp_quat_z;
            got_record.button_valid   = rsp_button_valid;
            got_record.button_pressed = rsp_button_pressed;
            if (expected_records.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result: %s", format_record(got_record));
               mismatch_count++;
            end else begin
               want_record = expected_records.pop_front();
               if (got_record.status         !== want_record.status         ||
                   got_record.station        !== want_record.station        ||
                   got_record.pos_x          !== want_record.pos_x          ||
                   got_record.pos_y          !== want_record.pos_y          ||
                   got_record.pos_z          !== want_record.pos_z          ||
                   got_record.quat_w         !== want_record.quat_w         ||
                   got_record.quat_x         !== want_record.quat_x         ||
                   got_record.quat_y         !== want_record.quat_y         ||
                   got_record.quat_z         !== want_record.quat_z         ||
                   got_record.button_valid   !== want_record.button_valid   ||
                   got_record.button_pressed !== want_record.button_pressed) begin
                  if (mismatch_count < 10) begin
                     $display("record mismatch at cycle %0d", cycle_count);
                     $display("  expected %s", format_record(want_record));
                     $display("  actual   %s", format_record(got_record));
                  end
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      word_set_type edge_words_a;
      word_set_type edge_words_b;
      edge_words_a = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001};
      edge_words_b = '{16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'hFF80};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: both stations and both button codes with the buttons enabled.
      write_reg(CSR_STATION_COUNT, 2'd2);
      write_reg(CSR_BUTTON_MASK, 2'd3);
      set_pace(0, 0);
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'h7F);
      queue_record(STATION_BASE, CHAR_AT, edge_words_a, 0);
      queue_record(STATION_BASE + 8'd1, CHAR_STAR, edge_words_b, 0);
      // Other button byte: no button state.
      queue_record(STATION_BASE, 8'h41, edge_words_b, 0);
      // Station digit one past the count, and one below the base.
      queue_record(STATION_BASE + 8'd2, CHAR_AT, edge_words_a, 0);
      queue_record(STATION_BASE - 8'd1, CHAR_AT, edge_words_a, 0);
      // Stray sync in the last byte together with a bad station: stray wins.
      queue_record(STATION_BASE - 8'd1, CHAR_STAR, edge_words_b, REC_LEN - 1);
      // Stray sync in a group's high-bit byte.
      queue_record(STATION_BASE, CHAR_AT, edge_words_a, GROUP_LEN - 1);
      drain_link();

      // One station, button on station 0 only; no idling.
      write_reg(CSR_STATION_COUNT, 2'd1);
      write_reg(CSR_BUTTON_MASK, 2'd1);
      queue_random(PHASE_BYTES);
      drain_link();

      // Count above the maximum is clamped; button on station 1 only; sender idles.
      write_reg(CSR_STATION_COUNT, 2'd3);
      write_reg(CSR_BUTTON_MASK, 2'd2);
      set_pace(53, 0);
      queue_random(PHASE_BYTES);
      drain_link();

      // Zero stations rejects every record; receiver stalls.
      write_reg(CSR_STATION_COUNT, 2'd0);
      write_reg(CSR_BUTTON_MASK, 2'd0);
      set_pace(0, 53);
      queue_random(PHASE_BYTES);
      drain_link();

      // Back to two stations with both buttons; sender idles and receiver stalls.
      write_reg(CSR_STATION_COUNT, 2'd2);
      write_reg(CSR_BUTTON_MASK, 2'd3);
      set_pace(35, 35);
      queue_random(PHASE_BYTES);
      drain_link();

      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_records.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* tracker_binary_record_parser.f */
+incdir+design
design/tbrp_pkg.sv
design/tracker_binary_record_parser.sv
verif/testbench.sv
